@@ sv/ftl_pkg.sv @@
package ftl_pkg;

  localparam int BLOCK_COUNT       = 8;
  localparam int BLOCK_PAGES       = 8;
  localparam int MAX_LOGICAL_PAGES = 64;
  localparam int TOTAL_PAGES       = BLOCK_COUNT * BLOCK_PAGES;

  localparam int BLK_W = $clog2(BLOCK_COUNT);
  localparam int IDX_W = $clog2(BLOCK_PAGES);
  localparam int PG_W  = BLK_W + IDX_W;
  localparam int LPN_W = $clog2(MAX_LOGICAL_PAGES);
  localparam int CNT_W = BLK_W + 1;
  localparam int ENT_W = 10;

  localparam logic [1:0] PS_UNWRITTEN = 2'd0;
  localparam logic [1:0] PS_ERASED    = 2'd1;
  localparam logic [1:0] PS_VALID     = 2'd2;

  localparam logic [7:0] ERASED_BYTE = 8'h20;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TRIM  = 2'd2;
  localparam logic [1:0] OP_UPKEEP = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ILLEGAL  = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;
  localparam logic [1:0] ST_NOFREE   = 2'd3;

  localparam logic [1:0] MODE_DIRECT = 2'd0;
  localparam logic [1:0] MODE_IDEAL  = 2'd2;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_LPC  = 2'd1;
  localparam logic [1:0] CFG_LWM  = 2'd2;
  localparam logic [1:0] CFG_HWM  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] lpc;
    logic [3:0] lwm;
    logic [3:0] hwm;
  } cfg_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] rbyte;
    logic [5:0] phys;
  } res_t;

endpackage

@@ sv/ftl_ram.sv @@
module ftl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ftl_ctrl.sv @@
module ftl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  ftl_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    op,
  input  logic [6:0]    la,
  input  logic [7:0]    wb,
  output logic          res_valid,
  input  logic          res_free,
  output ftl_pkg::res_t res
);
  import ftl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RD_B, S_RD_C, S_IDW, S_DIR_A, S_DIR_B, S_DIRF,
    S_APP, S_CLM_A, S_CLM_B, S_ERS, S_PROG, S_FREE_A, S_FREE_B,
    S_CB, S_CB_B, S_CNXT, S_LV_A, S_LV_B, S_LV_C, S_LVE, S_RL, S_RL_B,
    S_RLN, S_DONE
  } state_t;

  localparam logic [BLK_W-1:0] BLK_LAST = BLK_W'(BLOCK_COUNT - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_PAGES - 1);

  state_t            state_r;
  logic [1:0]        op_r;
  logic [6:0]        la_r;
  logic [7:0]        wb_r;
  logic [IDX_W-1:0]  idx_r, eidx_r;
  logic [BLK_W-1:0]  blk_r, tries_r, cblk_r, ers_blk_r, open_blk_r, cstart_r;
  logic [3:0]        cleaned_r;
  logic [CNT_W-1:0]  fcnt_r;
  logic [BLOCK_PAGES-1:0] live_r;
  logic              revok_r, ers_col_r, reloc_r, cur_open_r;
  logic [LPN_W-1:0]  ala_r;
  logic [7:0]        dat_r;
  logic [PG_W-1:0]   rp_r, cursor_r;
  res_t              res_r;

  logic [TOTAL_PAGES-1:0]       pg_vld_r, rev_vld_r, rev_vld_nxt;
  logic [MAX_LOGICAL_PAGES-1:0] fwd_vld_r;
  logic                         pg_vq_r, fwd_vq_r, rev_vq_r;

  logic [PG_W-1:0]   pg_raddr, pg_waddr, rev_raddr, rev_waddr;
  logic [LPN_W-1:0]  fwd_raddr, fwd_waddr, rev_wdata;
  logic [ENT_W-1:0]  pg_wdata, pg_q;
  logic [PG_W-1:0]   fwd_wdata, fwd_q;
  logic [LPN_W-1:0]  rev_q;
  logic              pg_we, fwd_we, rev_we, fwd_clr, rev_clr;

  logic [6:0]        limit;
  logic              legal, logm;
  logic [1:0]        pst;
  logic [7:0]        pbyte;
  logic [LPN_W-1:0]  lpn;
  logic [PG_W-1:0]   la_pg, lv_pg, dir_pg;
  logic              lv_bit;
  logic [CNT_W-1:0]  fcnt_add;
  logic [3:0]        cleaned_add;

  assign limit = (cfg.lpc > 7'(MAX_LOGICAL_PAGES)) ? 7'(MAX_LOGICAL_PAGES) : cfg.lpc;
  assign legal = la_r < limit;
  assign logm  = cfg.mode[0];
  assign pst   = pg_vq_r ? pg_q[9:8] : PS_UNWRITTEN;
  assign pbyte = pg_vq_r ? pg_q[7:0] : ERASED_BYTE;
  assign lpn   = la_r[LPN_W-1:0];
  assign la_pg = la_r[PG_W-1:0];
  assign lv_pg = {cblk_r, idx_r};
  assign dir_pg = {la_r[PG_W-1:IDX_W], idx_r};
  assign lv_bit = revok_r && fwd_vq_r && (fwd_q == lv_pg);
  assign fcnt_add = fcnt_r + CNT_W'(pst != PS_VALID);
  assign cleaned_add = cleaned_r + 4'd1;

  ftl_ram #(.W(ENT_W), .DEPTH(TOTAL_PAGES)) u_page (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(pg_wdata),
    .raddr(pg_raddr), .rdata(pg_q)
  );
  ftl_ram #(.W(PG_W), .DEPTH(MAX_LOGICAL_PAGES)) u_fwd (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(fwd_raddr), .rdata(fwd_q)
  );
  ftl_ram #(.W(LPN_W), .DEPTH(TOTAL_PAGES)) u_rev (
    .clk(clk), .we(rev_we), .waddr(rev_waddr), .wdata(rev_wdata),
    .raddr(rev_raddr), .rdata(rev_q)
  );

  // memory requests follow the state alone; reads are consumed one state later
  always_comb begin
    pg_raddr  = '0;
    fwd_raddr = '0;
    rev_raddr = '0;
    pg_we     = 1'b0;
    pg_waddr  = '0;
    pg_wdata  = '0;
    fwd_we    = 1'b0;
    fwd_waddr = '0;
    fwd_wdata = '0;
    rev_we    = 1'b0;
    rev_waddr = '0;
    rev_wdata = '0;
    fwd_clr   = 1'b0;
    rev_clr   = 1'b0;
    unique case (state_r)
      S_DISP: begin
        fwd_raddr = lpn;
        fwd_clr   = (op_r == OP_TRIM) && legal;
      end
      S_RD_B:  pg_raddr = fwd_q;
      S_DIR_A: pg_raddr = dir_pg;
      S_DIR_B: begin
        pg_we    = 1'b1;
        pg_waddr = dir_pg;
        if (dir_pg == la_pg) begin
          pg_wdata = {PS_VALID, wb_r};
        end else if (pst == PS_VALID) begin
          pg_wdata = {PS_VALID, pbyte};
        end else begin
          pg_wdata = {PS_ERASED, ERASED_BYTE};
        end
      end
      S_IDW, S_DIRF: begin
        pg_we     = (state_r == S_IDW);
        pg_waddr  = la_pg;
        pg_wdata  = {PS_VALID, wb_r};
        fwd_we    = 1'b1;
        fwd_waddr = lpn;
        fwd_wdata = la_pg;
        rev_we    = 1'b1;
        rev_waddr = la_pg;
        rev_wdata = lpn;
      end
      S_CLM_A, S_FREE_A: pg_raddr = {blk_r, IDX_W'(0)};
      S_CB:    pg_raddr = {cblk_r, IDX_W'(0)};
      S_ERS: begin
        pg_we    = 1'b1;
        pg_waddr = {ers_blk_r, eidx_r};
        pg_wdata = {PS_ERASED, ERASED_BYTE};
      end
      S_PROG: begin
        pg_we     = 1'b1;
        pg_waddr  = cursor_r;
        pg_wdata  = {PS_VALID, dat_r};
        fwd_we    = 1'b1;
        fwd_waddr = ala_r;
        fwd_wdata = cursor_r;
        rev_we    = 1'b1;
        rev_waddr = cursor_r;
        rev_wdata = ala_r;
        rev_clr   = reloc_r;
      end
      S_LV_A:  rev_raddr = lv_pg;
      S_LV_B:  fwd_raddr = rev_q;
      S_RL: begin
        rev_raddr = lv_pg;
        pg_raddr  = lv_pg;
      end
      default: begin
      end
    endcase
  end

  // drop the relocated page's reverse entry and set the new one together
  always_comb begin
    rev_vld_nxt = rev_vld_r;
    if (rev_clr) begin
      rev_vld_nxt[rp_r] = 1'b0;
    end
    if (rev_we) begin
      rev_vld_nxt[rev_waddr] = 1'b1;
    end
  end

  // entry valid bits: a clear entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pg_vld_r  <= '0;
      fwd_vld_r <= '0;
      rev_vld_r <= '0;
      pg_vq_r   <= 1'b0;
      fwd_vq_r  <= 1'b0;
      rev_vq_r  <= 1'b0;
    end else begin
      if (pg_we) begin
        pg_vld_r[pg_waddr] <= 1'b1;
      end
      if (fwd_clr) begin
        fwd_vld_r[lpn] <= 1'b0;
      end
      if (fwd_we) begin
        fwd_vld_r[fwd_waddr] <= 1'b1;
      end
      rev_vld_r <= rev_vld_nxt;
      pg_vq_r  <= pg_vld_r[pg_raddr];
      fwd_vq_r <= fwd_vld_r[fwd_raddr];
      rev_vq_r <= rev_vld_r[rev_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_open_r <= 1'b0;
      cursor_r   <= '0;
      open_blk_r <= '0;
      cstart_r   <= '0;
      reloc_r    <= 1'b0;
      ers_col_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= op;
            la_r    <= la;
            wb_r    <= wb;
            res_r   <= '{status: ST_OK, rbyte: 8'd0, phys: 6'd0};
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          if (op_r == OP_UPKEEP) begin
            if (logm) begin
              fcnt_r  <= '0;
              blk_r   <= '0;
              state_r <= S_FREE_A;
            end else begin
              state_r <= S_DONE;
            end
          end else if (!legal) begin
            res_r.status <= ST_ILLEGAL;
            state_r      <= S_DONE;
          end else if (op_r == OP_READ) begin
            if (!fwd_vld_r[lpn]) begin
              res_r.status <= ST_UNMAPPED;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_RD_B;
            end
          end else if (op_r == OP_TRIM) begin
            if (!fwd_vld_r[lpn]) begin
              res_r.status <= ST_UNMAPPED;
            end
            state_r <= S_DONE;
          end else if (logm) begin
            ala_r   <= lpn;
            dat_r   <= wb_r;
            reloc_r <= 1'b0;
            state_r <= S_APP;
          end else if (cfg.mode == MODE_IDEAL) begin
            state_r <= S_IDW;
          end else begin
            idx_r   <= '0;
            state_r <= S_DIR_A;
          end
        end
        S_RD_B: begin
          rp_r    <= fwd_q;
          state_r <= S_RD_C;
        end
        S_RD_C: begin
          res_r.rbyte <= pbyte;
          res_r.phys  <= 6'(rp_r);
          state_r     <= S_DONE;
        end
        S_IDW, S_DIRF: begin
          res_r.phys <= 6'(la_pg);
          state_r    <= S_DONE;
        end
        S_DIR_A: state_r <= S_DIR_B;
        S_DIR_B: begin
          idx_r   <= idx_r + 1'b1;
          state_r <= (idx_r == IDX_LAST) ? S_DIRF : S_DIR_A;
        end
        S_APP: begin
          if (cur_open_r) begin
            state_r <= S_PROG;
          end else begin
            tries_r <= '0;
            blk_r   <= open_blk_r;
            state_r <= S_CLM_A;
          end
        end
        S_CLM_A: state_r <= S_CLM_B;
        S_CLM_B: begin
          if (pst == PS_VALID) begin
            if (tries_r == BLK_LAST) begin
              res_r.status <= ST_NOFREE;
              state_r      <= S_DONE;
            end else begin
              tries_r <= tries_r + 1'b1;
              blk_r   <= blk_r + 1'b1;
              state_r <= S_CLM_A;
            end
          end else if (pst == PS_UNWRITTEN) begin
            ers_blk_r <= blk_r;
            ers_col_r <= 1'b0;
            eidx_r    <= '0;
            state_r   <= S_ERS;
          end else begin
            cursor_r   <= {blk_r, IDX_W'(0)};
            cur_open_r <= 1'b1;
            open_blk_r <= blk_r;
            state_r    <= S_PROG;
          end
        end
        S_ERS: begin
          eidx_r <= eidx_r + 1'b1;
          if (eidx_r == IDX_LAST) begin
            if (ers_col_r) begin
              if (cleaned_add >= cfg.hwm) begin
                cstart_r <= cblk_r;
                state_r  <= S_DONE;
              end else begin
                cleaned_r <= cleaned_add;
                state_r   <= S_CNXT;
              end
            end else begin
              cursor_r   <= {blk_r, IDX_W'(0)};
              cur_open_r <= 1'b1;
              open_blk_r <= blk_r;
              state_r    <= S_PROG;
            end
          end
        end
        S_PROG: begin
          cursor_r <= cursor_r + 1'b1;
          if (cursor_r[IDX_W-1:0] == IDX_LAST) begin
            cur_open_r <= 1'b0;
          end
          if (reloc_r) begin
            state_r <= S_RLN;
          end else begin
            res_r.phys <= 6'(cursor_r);
            state_r    <= S_DONE;
          end
        end
        S_FREE_A: state_r <= S_FREE_B;
        S_FREE_B: begin
          fcnt_r <= fcnt_add;
          blk_r  <= blk_r + 1'b1;
          if (blk_r != BLK_LAST) begin
            state_r <= S_FREE_A;
          end else if (int'(fcnt_add) <= int'(cfg.lwm)) begin
            cblk_r    <= cstart_r;
            cleaned_r <= '0;
            state_r   <= S_CB;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_CB: state_r <= (cblk_r == open_blk_r) ? S_CNXT : S_CB_B;
        S_CB_B: begin
          if (pst == PS_ERASED) begin
            state_r <= S_CNXT;
          end else begin
            idx_r   <= '0;
            live_r  <= '0;
            state_r <= S_LV_A;
          end
        end
        S_CNXT: begin
          if (cblk_r == BLK_LAST) begin
            state_r <= S_DONE;
          end else begin
            cblk_r  <= cblk_r + 1'b1;
            state_r <= S_CB;
          end
        end
        S_LV_A: state_r <= S_LV_B;
        S_LV_B: begin
          revok_r <= rev_vq_r;
          state_r <= S_LV_C;
        end
        S_LV_C: begin
          live_r[idx_r] <= lv_bit;
          idx_r         <= idx_r + 1'b1;
          state_r       <= (idx_r == IDX_LAST) ? S_LVE : S_LV_A;
        end
        S_LVE: begin
          if (&live_r) begin
            state_r <= S_CNXT;
          end else begin
            idx_r   <= '0;
            state_r <= S_RL;
          end
        end
        S_RL: begin
          if (live_r[idx_r]) begin
            state_r <= S_RL_B;
          end else begin
            state_r <= S_RLN;
          end
        end
        S_RL_B: begin
          ala_r   <= rev_q;
          dat_r   <= pbyte;
          rp_r    <= lv_pg;
          reloc_r <= 1'b1;
          state_r <= S_APP;
        end
        S_RLN: begin
          if (idx_r == IDX_LAST) begin
            ers_blk_r <= cblk_r;
            ers_col_r <= 1'b1;
            eidx_r    <= '0;
            state_r   <= S_ERS;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RL;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

@@ sv/flash_translation_layer_core.sv @@
// A log write may include a block claim and erase, and upkeep may run a collection
// pass that walks each block's pages through the maps.
// One request is in flight at a time; the sequencer over the page, forward and
// reverse memories sets the rate. A new request is taken while a result waits.
// Reset is synchronous: maps and page states read as cleared at once, no sweep.
module flash_translation_layer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_op,
  input  logic [6:0] in_logical_address,
  input  logic [7:0] in_write_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_read_byte,
  output logic [5:0] out_physical_page,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);
  import ftl_pkg::*;

  cfg_t cfg_r;
  res_t res, out_r;
  logic res_valid, res_free, out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{mode: MODE_DIRECT, lpc: 7'd50, lwm: 4'd8, hwm: 4'd8};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MODE: cfg_r.mode <= cfg_data[1:0];
        CFG_LPC:  cfg_r.lpc  <= cfg_data;
        CFG_LWM:  cfg_r.lwm  <= cfg_data[3:0];
        CFG_HWM:  cfg_r.hwm  <= cfg_data[3:0];
        default:  cfg_r      <= cfg_r;
      endcase
    end
  end

  ftl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(in_op), .la(in_logical_address), .wb(in_write_byte),
    .res_valid(res_valid), .res_free(res_free), .res(res)
  );

  assign res_free = !out_valid_r || out_ready;

  // output register: hold the transaction until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_read_byte     = out_r.rbyte;
  assign out_physical_page = out_r.phys;

endmodule

@@ sim/flash_translation_layer_core_tb.sv @@
module flash_translation_layer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftl_pkg::*;

  localparam logic [1:0] MODE_LOG     = 2'd1;
  localparam logic [1:0] MODE_LOG_ALT = 2'd3;
  localparam int         CYCLE_LIMIT  = 10000000;
  localparam int         ITEMS_PER_PHASE = 65;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_op = OP_READ;
  logic [6:0] in_logical_address = '0;
  logic [7:0] in_write_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_read_byte;
  logic [5:0] out_physical_page;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_MODE;
  logic [6:0] cfg_data = '0;

  flash_translation_layer_core dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Mirror of the translation layer: page store, maps, log cursor and registers
  logic [1:0] pg_state [TOTAL_PAGES];
  logic [7:0] pg_byte  [TOTAL_PAGES];
  int         fwd_map  [MAX_LOGICAL_PAGES];
  bit         fwd_ok   [MAX_LOGICAL_PAGES];
  int         rev_map  [TOTAL_PAGES];
  bit         rev_ok   [TOTAL_PAGES];
  int         cursor;
  bit         cursor_open;
  int         open_blk;
  int         gc_start_blk;
  cfg_t       regs;

  res_t pending_results [$];
  int   fail_count = 0;
  int   cycle_count = 0;
  bit   hold_req = 1'b0;
  int   burst_left = 0;

  function automatic void erase_blk(int b);
    for (int i = 0; i < BLOCK_PAGES; i++) begin
      pg_byte[b*BLOCK_PAGES + i]  = ERASED_BYTE;
      pg_state[b*BLOCK_PAGES + i] = PS_ERASED;
    end
  endfunction

  function automatic void program_pg(int p, logic [7:0] d);
    pg_state[p] = PS_VALID;
    pg_byte[p]  = d;
  endfunction

  function automatic bit try_claim(int b);
    int base;
    base = b * BLOCK_PAGES;
    if (pg_state[base] == PS_VALID) return 1'b0;
    if (pg_state[base] == PS_UNWRITTEN) erase_blk(b);
    cursor      = base;
    cursor_open = 1'b1;
    open_blk    = b;
    return 1'b1;
  endfunction

  function automatic bit claim_free_blk();
    int first;
    first = (open_blk < BLOCK_COUNT) ? open_blk : 0;
    for (int b = first; b < BLOCK_COUNT; b++)
      if (try_claim(b)) return 1'b1;
    for (int b = 0; b < first; b++)
      if (try_claim(b)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit append_log(int la, logic [7:0] d, output int pp);
    int p;
    pp = 0;
    if (!cursor_open) begin
      if (!claim_free_blk()) return 1'b0;
    end
    p = cursor;
    if (p >= TOTAL_PAGES || la >= MAX_LOGICAL_PAGES) return 1'b0;
    program_pg(p, d);
    fwd_map[la] = p;
    fwd_ok[la]  = 1'b1;
    rev_map[p]  = la;
    rev_ok[p]   = 1'b1;
    cursor = p + 1;
    if (cursor % BLOCK_PAGES == 0) cursor_open = 1'b0;
    pp = p;
    return 1'b1;
  endfunction

  function automatic void rewrite_direct(int la, logic [7:0] d);
    int         base;
    logic [7:0] kept [BLOCK_PAGES];
    bit         was_valid [BLOCK_PAGES];
    base = (la / BLOCK_PAGES) * BLOCK_PAGES;
    for (int i = 0; i < BLOCK_PAGES; i++) begin
      was_valid[i] = pg_state[base + i] == PS_VALID;
      kept[i]      = pg_byte[base + i];
    end
    erase_blk(la / BLOCK_PAGES);
    for (int i = 0; i < BLOCK_PAGES; i++)
      if (base + i != la && was_valid[i]) program_pg(base + i, kept[i]);
    program_pg(la, d);
    fwd_map[la] = la;
    fwd_ok[la]  = 1'b1;
    rev_map[la] = la;
    rev_ok[la]  = 1'b1;
  endfunction

  function automatic logic [1:0] collect_garbage();
    int cleaned;
    int base;
    int n;
    int la;
    int dummy;
    int live_pg [BLOCK_PAGES];
    cleaned = 0;
    for (int b = gc_start_blk; b < BLOCK_COUNT; b++) begin
      base = b * BLOCK_PAGES;
      if (b == open_blk || pg_state[base] == PS_ERASED) continue;
      n = 0;
      for (int p = base; p < base + BLOCK_PAGES; p++) begin
        la = rev_map[p];
        if (rev_ok[p] && la < MAX_LOGICAL_PAGES && fwd_ok[la] && fwd_map[la] == p) begin
          live_pg[n] = p;
          n++;
        end
      end
      if (n == BLOCK_PAGES) continue;
      // relocate live pages through the log; hold the reverse entry on failure
      for (int i = 0; i < n; i++) begin
        rev_ok[live_pg[i]] = 1'b0;
        if (!append_log(rev_map[live_pg[i]], pg_byte[live_pg[i]], dummy)) begin
          rev_ok[live_pg[i]] = 1'b1;
          return ST_NOFREE;
        end
      end
      erase_blk(b);
      cleaned++;
      if (cleaned >= regs.hwm) begin
        gc_start_blk = b;
        return ST_OK;
      end
    end
    return ST_OK;
  endfunction

  function automatic res_t ftl_predict(logic [1:0] op, logic [6:0] addr, logic [7:0] wb);
    res_t r;
    int   limit;
    int   la;
    int   free_blks;
    int   pp;
    bit   log_mode;
    r = '0;
    la = int'(addr);
    limit = (regs.lpc < MAX_LOGICAL_PAGES) ? int'(regs.lpc) : MAX_LOGICAL_PAGES;
    log_mode = regs.mode == MODE_LOG || regs.mode == MODE_LOG_ALT;
    if (op == OP_UPKEEP) begin
      if (log_mode) begin
        free_blks = 0;
        for (int b = 0; b < BLOCK_COUNT; b++)
          if (pg_state[b*BLOCK_PAGES] != PS_VALID) free_blks++;
        if (free_blks <= regs.lwm) r.status = collect_garbage();
      end
    end else if (la >= limit) begin
      r.status = ST_ILLEGAL;
    end else if (op == OP_READ) begin
      if (!fwd_ok[la] || fwd_map[la] >= TOTAL_PAGES) begin
        r.status = ST_UNMAPPED;
      end else begin
        r.phys  = 6'(fwd_map[la]);
        r.rbyte = pg_byte[fwd_map[la]];
      end
    end else if (op == OP_TRIM) begin
      if (!fwd_ok[la]) r.status = ST_UNMAPPED;
      else fwd_ok[la] = 1'b0;
    end else if (log_mode) begin
      if (append_log(la, wb, pp)) r.phys = 6'(pp);
      else r.status = ST_NOFREE;
    end else if (la >= TOTAL_PAGES) begin
      r.status = ST_ILLEGAL;
    end else if (regs.mode == MODE_DIRECT) begin
      rewrite_direct(la, wb);
      r.phys = 6'(la);
    end else begin
      program_pg(la, wb);
      fwd_map[la] = la;
      fwd_ok[la]  = 1'b1;
      rev_map[la] = la;
      rev_ok[la]  = 1'b1;
      r.phys = 6'(la);
    end
    return r;
  endfunction

  // Directed stimulus: either a register write or a request, optionally with a typed result
  typedef struct {
    bit         is_cfg;
    logic [1:0] op;
    logic [6:0] addr;
    logic [7:0] wb;
    bit         typed;
    res_t       res;
  } step_t;

  step_t steps [$];

  function automatic void add_req(logic [1:0] op, logic [6:0] addr, logic [7:0] wb);
    steps.push_back('{1'b0, op, addr, wb, 1'b0, res_t'(0)});
  endfunction

  function automatic void add_chk(logic [1:0] op, logic [6:0] addr, logic [7:0] wb,
                                  logic [1:0] st, logic [7:0] rb, logic [5:0] ph);
    res_t r;
    r.status = st;
    r.rbyte  = rb;
    r.phys   = ph;
    steps.push_back('{1'b0, op, addr, wb, 1'b1, r});
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [6:0] data);
    steps.push_back('{1'b1, idx, data, 8'd0, 1'b0, res_t'(0)});
  endfunction

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] data);
    drain();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE: regs.mode = data[1:0];
      CFG_LPC:  regs.lpc  = data;
      CFG_LWM:  regs.lwm  = data[3:0];
      CFG_HWM:  regs.hwm  = data[3:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic send_req(logic [1:0] op, logic [6:0] addr, logic [7:0] wb,
                          bit typed, res_t typed_res);
    res_t r;
    in_valid           <= 1'b1;
    in_op              <= op;
    in_logical_address <= addr;
    in_write_byte      <= wb;
    do @(posedge clk); while (!in_ready);
    r = ftl_predict(op, addr, wb);
    pending_results.push_back(typed ? typed_res : r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  task automatic run_phase(logic [1:0] mode, logic [6:0] lpc, logic [3:0] lwm,
                           logic [3:0] hwm, bit with_hold);
    int         span;
    int         sel;
    logic [1:0] op;
    logic [6:0] addr;
    write_reg(CFG_MODE, 7'(mode));
    write_reg(CFG_LPC, lpc);
    write_reg(CFG_LWM, 7'(lwm));
    write_reg(CFG_HWM, 7'(hwm));
    // keep most addresses in a narrow window so log blocks fill with stale pages
    span = (lpc < 16) ? ((lpc == 0) ? 1 : int'(lpc)) : 16;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      if (with_hold && i == 20) hold_req = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel < 2 || sel == 9) op = OP_READ;
      else if (sel < 6) op = OP_WRITE;
      else if (sel == 6) op = OP_TRIM;
      else op = OP_UPKEEP;
      addr = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, span - 1));
      send_req(op, addr, 8'($urandom_range(0, 255)), 1'b0, res_t'(0));
    end
  endtask

  // Result side: stall in changing patterns, and once hold off for a long stretch
  initial begin
    int pattern;
    int left;
    pattern = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      if (left == 0) begin
        pattern = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      case (pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= (left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding: status %0d byte %h page %0d",
                 $time, out_status, out_read_byte, out_physical_page);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          fail_count++;
        end
        if (out_read_byte !== want.rbyte) begin
          $display("%0t: read_byte expected %h actual %h", $time, want.rbyte, out_read_byte);
          fail_count++;
        end
        if (out_physical_page !== want.phys) begin
          $display("%0t: physical_page expected %0d actual %0d",
                   $time, want.phys, out_physical_page);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < TOTAL_PAGES; p++) begin
      pg_state[p] = PS_UNWRITTEN;
      pg_byte[p]  = ERASED_BYTE;
      rev_map[p]  = 0;
      rev_ok[p]   = 1'b0;
    end
    for (int l = 0; l < MAX_LOGICAL_PAGES; l++) begin
      fwd_map[l] = 0;
      fwd_ok[l]  = 1'b0;
    end
    cursor = 0;
    cursor_open = 1'b0;
    open_blk = 0;
    gc_start_blk = 0;
    regs.mode = MODE_DIRECT;
    regs.lpc  = 7'd50;
    regs.lwm  = 4'd8;
    regs.hwm  = 4'd8;

    add_chk(OP_READ,   7'd0,   8'h00, ST_UNMAPPED, 8'h00, 6'd0);
    add_chk(OP_READ,   7'd127, 8'h00, ST_ILLEGAL,  8'h00, 6'd0);
    add_chk(OP_WRITE,  7'd50,  8'h12, ST_ILLEGAL,  8'h00, 6'd0);
    add_chk(OP_WRITE,  7'd0,   8'hff, ST_OK,       8'h00, 6'd0);
    add_chk(OP_READ,   7'd0,   8'h00, ST_OK,       8'hff, 6'd0);
    add_chk(OP_WRITE,  7'd49,  8'h00, ST_OK,       8'h00, 6'd49);
    add_req(OP_WRITE,  7'd1,   8'h55);
    add_req(OP_READ,   7'd0,   8'h00);
    add_chk(OP_TRIM,   7'd49,  8'h00, ST_OK,       8'h00, 6'd0);
    add_chk(OP_TRIM,   7'd49,  8'h00, ST_UNMAPPED, 8'h00, 6'd0);
    add_chk(OP_READ,   7'd49,  8'h00, ST_UNMAPPED, 8'h00, 6'd0);
    add_chk(OP_UPKEEP, 7'd0,   8'h00, ST_OK,       8'h00, 6'd0);
    add_cfg(CFG_LPC, 7'd64);
    add_cfg(CFG_MODE, 7'(MODE_IDEAL));
    add_chk(OP_WRITE,  7'd63,  8'haa, ST_OK,       8'h00, 6'd63);
    add_req(OP_READ,   7'd63,  8'h00);
    add_cfg(CFG_MODE, 7'(MODE_LOG));
    add_cfg(CFG_HWM, 7'd0);
    add_req(OP_WRITE,  7'd5,   8'h11);
    add_req(OP_WRITE,  7'd5,   8'h22);
    add_req(OP_WRITE,  7'd6,   8'h33);
    add_req(OP_UPKEEP, 7'd0,   8'h00);
    add_req(OP_READ,   7'd5,   8'h00);
    add_cfg(CFG_MODE, 7'(MODE_LOG_ALT));
    add_req(OP_WRITE,  7'd7,   8'h01);
    add_req(OP_UPKEEP, 7'd0,   8'h00);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].is_cfg) write_reg(steps[i].op, steps[i].addr);
      else send_req(steps[i].op, steps[i].addr, steps[i].wb, steps[i].typed, steps[i].res);
    end

    run_phase(MODE_LOG,     7'd64, 4'd8, 4'd1, 1'b1);
    run_phase(MODE_LOG_ALT, 7'd32, 4'd3, 4'd2, 1'b0);
    run_phase(MODE_DIRECT,  7'd64, 4'd0, 4'd8, 1'b0);
    run_phase(MODE_IDEAL,   7'd1,  4'd8, 4'd8, 1'b0);
    run_phase(MODE_LOG,     7'd20, 4'd8, 4'd0, 1'b0);
    run_phase(MODE_LOG,     7'($urandom_range(1, 64)), 4'($urandom_range(0, 8)),
              4'($urandom_range(1, 8)), 1'b0);

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
